/* rtl/pmpt_pkg.sv */
// Package for the prefix match peer table: field widths, item codes and the
// control word that travels from the front part to the back part.
// No dependencies.
package pmpt_pkg;

  localparam int SLOTS_DEFAULT        = 16;
  localparam int ADDRESS_BITS_DEFAULT = 32;

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 4;
  localparam int FAMILY_W = 2;
  localparam int PREFIX_W = 6;
  localparam int KIND_W   = 3;
  localparam int MODE_W   = 2;
  localparam int OP_W     = 2;
  // Query length holds a prefix length or the full address length (up to 127).
  localparam int QLEN_W   = 7;

  localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INVAL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SUBNET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROUTE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_INCOMPLETE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOCAL      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_STATIC     = 3'd6;

  // Operation classes decided by the front part.
  localparam logic [OP_W-1:0] OP_NONE   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   slot;
    logic [FAMILY_W-1:0] family;
    logic [PREFIX_W-1:0] prefix;
    logic [KIND_W-1:0]   kind;
    logic [MODE_W-1:0]   mode;
    logic [QLEN_W-1:0]   qlen;
    logic                skip_inc;
    logic                skip_rem;
  } pmpt_ctl_t;

endpackage

/* rtl/pmpt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pmpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/pmpt_front.sv */
// Front part of the prefix match peer table: accepts items, classifies them
// and holds them in a two-entry queue for the back part. Uses pmpt_pkg.
module pmpt_front #(
  parameter int SLOTS        = pmpt_pkg::SLOTS_DEFAULT,
  parameter int ADDRESS_BITS = pmpt_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pmpt_pkg::ACTION_W-1:0] action,
  input  logic [pmpt_pkg::SLOT_W-1:0]   slot,
  input  logic [ADDRESS_BITS-1:0]       address,
  input  logic [pmpt_pkg::FAMILY_W-1:0] addr_family,
  input  logic [pmpt_pkg::PREFIX_W-1:0] prefix_len,
  input  logic [pmpt_pkg::KIND_W-1:0]   entry_kind,
  input  logic [pmpt_pkg::MODE_W-1:0]   match_mode,
  input  logic                          use_full_length,
  input  logic                          skip_incomplete,
  input  logic                          skip_removable,
  output logic                          q_valid,
  output pmpt_pkg::pmpt_ctl_t           q_ctl,
  output logic [ADDRESS_BITS-1:0]       q_addr,
  input  logic                          q_pop
);
  import pmpt_pkg::*;

  pmpt_ctl_t             ctl;
  logic                  slot_ok;
  logic                  push;
  pmpt_ctl_t             ctl_mem [2];
  logic [ADDRESS_BITS-1:0] addr_mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  assign slot_ok = int'(slot) < SLOTS;

  always_comb begin
    ctl.slot     = slot;
    ctl.family   = addr_family;
    ctl.prefix   = prefix_len;
    ctl.kind     = entry_kind;
    ctl.mode     = match_mode;
    ctl.qlen     = use_full_length ? QLEN_W'(ADDRESS_BITS) : QLEN_W'(prefix_len);
    ctl.skip_inc = skip_incomplete;
    ctl.skip_rem = skip_removable;
    case (action)
      ACT_WRITE:  ctl.op = slot_ok ? OP_WRITE : OP_NONE;
      ACT_INVAL:  ctl.op = slot_ok ? OP_INVAL : OP_NONE;
      ACT_LOOKUP: begin
        ctl.op = (match_mode inside {MODE_SUBNET, MODE_ROUTE, MODE_EXACT}) ?
                 OP_LOOKUP : OP_NONE;
      end
      default:    ctl.op = OP_NONE;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_ctl    = ctl_mem[rd_ptr];
  assign q_addr   = addr_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr]  <= ctl;
      addr_mem[wr_ptr] <= address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/pmpt_back.sv */
// Back part of the prefix match peer table: carries out writes, invalidates
// and lookups against the entry RAM, and holds the result register.
// Uses pmpt_pkg; drives the ports of one pmpt_ram.
module pmpt_back #(
  parameter int SLOTS        = pmpt_pkg::SLOTS_DEFAULT,
  parameter int ADDRESS_BITS = pmpt_pkg::ADDRESS_BITS_DEFAULT,
  parameter int IDX_W        = $clog2(SLOTS),
  parameter int ENTRY_W      = ADDRESS_BITS + pmpt_pkg::FAMILY_W +
                               pmpt_pkg::PREFIX_W + pmpt_pkg::KIND_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  pmpt_pkg::pmpt_ctl_t           q_ctl,
  input  logic [ADDRESS_BITS-1:0]       q_addr,
  output logic                          q_pop,
  output logic                          ram_wr_en,
  output logic [IDX_W-1:0]              ram_wr_addr,
  output logic [ENTRY_W-1:0]            ram_wr_data,
  output logic [IDX_W-1:0]              ram_rd_addr,
  input  logic [ENTRY_W-1:0]            ram_rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [pmpt_pkg::SLOT_W-1:0]   hit_slot,
  output logic [pmpt_pkg::PREFIX_W-1:0] hit_prefix_len,
  output logic [pmpt_pkg::KIND_W-1:0]   hit_kind,
  output logic [ADDRESS_BITS-1:0]       hit_address
);
  import pmpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;

  logic [1:0]              state;
  logic [IDX_W-1:0]        idx;
  logic [SLOTS-1:0]        entry_valid;
  pmpt_ctl_t               cur;
  logic [ADDRESS_BITS-1:0] cur_addr;

  // Compare stage: one entry per cycle, in the cycle after its RAM read.
  logic                    chk_go;
  logic                    chk_last;
  logic                    chk_vld;
  logic [IDX_W-1:0]        chk_idx;

  logic                    found;
  logic [IDX_W-1:0]        best_idx;
  logic [PREFIX_W-1:0]     best_prefix;
  logic [KIND_W-1:0]       best_kind;
  logic [ADDRESS_BITS-1:0] best_addr;

  logic [ADDRESS_BITS-1:0] e_addr;
  logic [FAMILY_W-1:0]     e_fam;
  logic [PREFIX_W-1:0]     e_pre;
  logic [KIND_W-1:0]       e_kind;
  logic [QLEN_W-1:0]       p_len;
  logic [QLEN_W-1:0]       cmp_len;
  logic                    mode_ok;
  logic                    skipped;
  logic                    addr_eq;
  logic                    take;
  logic                    found_next;
  logic [IDX_W-1:0]        best_idx_next;
  logic [PREFIX_W-1:0]     best_prefix_next;
  logic [KIND_W-1:0]       best_kind_next;
  logic [ADDRESS_BITS-1:0] best_addr_next;

  function automatic logic [ADDRESS_BITS-1:0] lead_mask(input logic [QLEN_W-1:0] len);
    logic [QLEN_W-1:0] l;
    l = (len > QLEN_W'(ADDRESS_BITS)) ? QLEN_W'(ADDRESS_BITS) : len;
    if (l == '0) begin
      return '0;
    end
    return {ADDRESS_BITS{1'b1}} << (QLEN_W'(ADDRESS_BITS) - l);
  endfunction

  assign q_pop       = (state == ST_IDLE) && q_valid && !out_valid;
  assign ram_wr_en   = q_pop && (q_ctl.op == OP_WRITE);
  assign ram_wr_addr = IDX_W'(q_ctl.slot);
  assign ram_wr_data = {q_addr, q_ctl.family, q_ctl.prefix, q_ctl.kind};
  assign ram_rd_addr = idx;

  always_comb begin
    {e_addr, e_fam, e_pre, e_kind} = ram_rd_data;
    p_len = QLEN_W'(e_pre);
    case (cur.mode)
      MODE_SUBNET: begin
        mode_ok = cur.qlen <= p_len;
        cmp_len = cur.qlen;
      end
      MODE_ROUTE: begin
        mode_ok = cur.qlen >= p_len;
        cmp_len = p_len;
      end
      MODE_EXACT: begin
        mode_ok = cur.qlen == p_len;
        cmp_len = cur.qlen;
      end
      default: begin
        mode_ok = 1'b0;
        cmp_len = cur.qlen;
      end
    endcase
    skipped = (cur.skip_inc && (e_kind == KIND_INCOMPLETE)) ||
              (cur.skip_rem && (e_kind inside {KIND_LOCAL, KIND_STATIC}));
    addr_eq = ((cur_addr ^ e_addr) & lead_mask(cmp_len)) == '0;
    // On equal prefix lengths the later slot replaces the earlier one.
    take = chk_go && chk_vld && (e_fam == cur.family) && mode_ok && !skipped &&
           addr_eq && (!found || !(best_prefix > e_pre));
    found_next       = found || take;
    best_idx_next    = take ? chk_idx : best_idx;
    best_prefix_next = take ? e_pre   : best_prefix;
    best_kind_next   = take ? e_kind  : best_kind;
    best_addr_next   = take ? e_addr  : best_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      entry_valid <= '0;
      chk_go      <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      chk_go <= (state == ST_SCAN);
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cur      <= q_ctl;
            cur_addr <= q_addr;
            case (q_ctl.op)
              OP_WRITE:  entry_valid[IDX_W'(q_ctl.slot)] <= 1'b1;
              OP_INVAL:  entry_valid[IDX_W'(q_ctl.slot)] <= 1'b0;
              default:   ;
            endcase
            if (q_ctl.op == OP_LOOKUP) begin
              state <= ST_SCAN;
              idx   <= '0;
              found <= 1'b0;
            end else begin
              out_valid      <= 1'b1;
              hit            <= 1'b0;
              hit_slot       <= '0;
              hit_prefix_len <= '0;
              hit_kind       <= '0;
              hit_address    <= '0;
            end
          end
        end
        ST_SCAN: begin
          chk_idx  <= idx;
          chk_vld  <= entry_valid[idx];
          chk_last <= (idx == IDX_W'(SLOTS - 1));
          if (idx == IDX_W'(SLOTS - 1)) begin
            state <= ST_TAIL;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_TAIL: begin
          if (chk_go && chk_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (chk_go) begin
        found       <= found_next;
        best_idx    <= best_idx_next;
        best_prefix <= best_prefix_next;
        best_kind   <= best_kind_next;
        best_addr   <= best_addr_next;
        if (chk_last) begin
          out_valid      <= 1'b1;
          hit            <= found_next;
          hit_slot       <= found_next ? SLOT_W'(best_idx_next) : '0;
          hit_prefix_len <= found_next ? best_prefix_next : '0;
          hit_kind       <= found_next ? best_kind_next : '0;
          hit_address    <= found_next ? best_addr_next : '0;
        end
      end
    end
  end

endmodule

/* rtl/prefix_match_peer_table.sv */
// Prefix match peer table. Every item yields one result item. A write,
// invalidate or other non-lookup item has its result registered by the back
// part as it leaves the two-entry input queue; for a lookup the back part reads
// the entry RAM through its single read port one slot per cycle, compares each
// entry as its data returns and registers the result after the last compare.
// Longest prefix wins and a tie goes to the highest slot. The queue accepts new
// items while a lookup runs or a result waits, until it holds two. Slot valid
// bits are cleared directly by reset; there is no clearing pass.
module prefix_match_peer_table #(
  parameter int SLOTS        = pmpt_pkg::SLOTS_DEFAULT,
  parameter int ADDRESS_BITS = pmpt_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pmpt_pkg::ACTION_W-1:0] action,
  input  logic [pmpt_pkg::SLOT_W-1:0]   slot,
  input  logic [ADDRESS_BITS-1:0]       address,
  input  logic [pmpt_pkg::FAMILY_W-1:0] addr_family,
  input  logic [pmpt_pkg::PREFIX_W-1:0] prefix_len,
  input  logic [pmpt_pkg::KIND_W-1:0]   entry_kind,
  input  logic [pmpt_pkg::MODE_W-1:0]   match_mode,
  input  logic                          use_full_length,
  input  logic                          skip_incomplete,
  input  logic                          skip_removable,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [pmpt_pkg::SLOT_W-1:0]   hit_slot,
  output logic [pmpt_pkg::PREFIX_W-1:0] hit_prefix_len,
  output logic [pmpt_pkg::KIND_W-1:0]   hit_kind,
  output logic [ADDRESS_BITS-1:0]       hit_address
);
  import pmpt_pkg::*;

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int ENTRY_W = ADDRESS_BITS + FAMILY_W + PREFIX_W + KIND_W;

  logic                    q_valid;
  pmpt_ctl_t               q_ctl;
  logic [ADDRESS_BITS-1:0] q_addr;
  logic                    q_pop;
  logic                    ram_wr_en;
  logic [IDX_W-1:0]        ram_wr_addr;
  logic [ENTRY_W-1:0]      ram_wr_data;
  logic [IDX_W-1:0]        ram_rd_addr;
  logic [ENTRY_W-1:0]      ram_rd_data;

  pmpt_front #(
    .SLOTS        (SLOTS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .slot            (slot),
    .address         (address),
    .addr_family     (addr_family),
    .prefix_len      (prefix_len),
    .entry_kind      (entry_kind),
    .match_mode      (match_mode),
    .use_full_length (use_full_length),
    .skip_incomplete (skip_incomplete),
    .skip_removable  (skip_removable),
    .q_valid         (q_valid),
    .q_ctl           (q_ctl),
    .q_addr          (q_addr),
    .q_pop           (q_pop)
  );

  pmpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pmpt_back #(
    .SLOTS        (SLOTS),
    .ADDRESS_BITS (ADDRESS_BITS),
    .IDX_W        (IDX_W),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ctl          (q_ctl),
    .q_addr         (q_addr),
    .q_pop          (q_pop),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .hit_slot       (hit_slot),
    .hit_prefix_len (hit_prefix_len),
    .hit_kind       (hit_kind),
    .hit_address    (hit_address)
  );

  // The back part takes an item only from a non-empty queue.
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A new item starts only once the previous result has been taken.
  a_pop_out_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !out_valid)
    else $error("item started while a result is still held");

  // An accepted item into an empty queue is visible to the back part next cycle.
  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !q_valid) |=> q_valid)
    else $error("accepted item lost in the queue");

  // The RAM is written only when a write item leaves the queue.
  a_write_on_pop: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> q_pop)
    else $error("entry RAM written outside an item start");

endmodule
